### rtl/rmth_pkg.sv
// Running median (two heaps): shared types and constants.
// No dependencies; compiled first.
package rmth_pkg;

   localparam int SAMPLE_W    = 32;
   localparam int COUNT_OUT_W = 11;

   // datapath operations issued by the controller
   typedef enum logic [3:0] {
      OP_NONE,
      OP_START,
      OP_SD_L,
      OP_SD_R,
      OP_SD_CMP,
      OP_SU_SET,
      OP_SU_CHK,
      OP_SU_CMP,
      OP_COUNT,
      OP_RESULT
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic full;     // store is at capacity
      logic swap;     // sample trades places with the other heap's top
      logic sd_leaf;  // sift-down node has no child
      logic sd_stop;  // sift-down value settles at this node
      logic su_root;  // sift-up reached the root
      logic su_stop;  // sift-up value settles at this node
   } sts_type;

endpackage

### rtl/rmth_if.sv
// Running median: valid/ready channel interfaces for samples and results.
// Depends on rmth_pkg.
interface rmth_req_if
   import rmth_pkg::*;
   ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface rmth_rsp_if
   import rmth_pkg::*;
   ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] median_whole;
   logic                       median_half;
   logic [COUNT_OUT_W-1:0]     held_count;
   logic                       full_res;
   modport source (output valid, output median_whole, output median_half,
                   output held_count, output full_res, input ready);
   modport sink   (input valid, input median_whole, input median_half,
                   input held_count, input full_res, output ready);
endinterface

### rtl/running_median_two_heaps_top.sv
// Channel   Dir  Payload                                          Transfer
// req_ch    in   sample                                           valid && ready
// rsp_ch    out  median_whole, median_half, held_count, full_res  valid && ready
//
// One item at a time, accept to next accept: take; on a swap, sift-down (left read,
// right read, compare per node with a child; left read alone at a leaf) and a climb
// set-up; sift-up (check, compare per node below the root; check at the root);
// count; result. A refused sample (store full) goes from take to count and result.
// Reset clears the count and the controller only. A waiting result does not block
// the next sample; the next result waits until the output register is free.
// Depends on rmth_pkg, rmth_if, rmth_ram, rmth_ctrl, rmth_dp.
module running_median_two_heaps_top
   import rmth_pkg::*;
#(
   parameter int CAPACITY = 1024
) (
   input  logic              clock,
   input  logic              reset,
   rmth_req_if.sink          req_ch,
   rmth_rsp_if.source        rsp_ch
);
   cmd_type cmd;
   sts_type sts;

   rmth_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rmth_dp #(.CAPACITY(CAPACITY)) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sample       (req_ch.sample),
      .sts          (sts),
      .median_whole (rsp_ch.median_whole),
      .median_half  (rsp_ch.median_half),
      .held_count   (rsp_ch.held_count),
      .full_res     (rsp_ch.full_res)
   );
endmodule

### rtl/rmth_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rmth_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

### rtl/rmth_ctrl.sv
// Running median controller: sequences insert, sift-down, sift-up, result.
// Depends on rmth_pkg.
module rmth_ctrl
   import rmth_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);
   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_SD_L   = 9'b000000010,
      ST_SD_R   = 9'b000000100,
      ST_SD_CMP = 9'b000001000,
      ST_SU_SET = 9'b000010000,
      ST_SU_CHK = 9'b000100000,
      ST_SU_CMP = 9'b001000000,
      ST_COUNT  = 9'b010000000,
      ST_RESULT = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.op       = OP_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op = OP_START;
               if (sts.full)      state_in = ST_COUNT;
               else if (sts.swap) state_in = ST_SD_L;
               else               state_in = ST_SU_CHK;
            end
         end
         ST_SD_L: begin
            cmd.op   = OP_SD_L;
            state_in = sts.sd_leaf ? ST_SU_SET : ST_SD_R;
         end
         ST_SD_R: begin
            cmd.op   = OP_SD_R;
            state_in = ST_SD_CMP;
         end
         ST_SD_CMP: begin
            cmd.op   = OP_SD_CMP;
            state_in = sts.sd_stop ? ST_SU_SET : ST_SD_L;
         end
         ST_SU_SET: begin
            cmd.op   = OP_SU_SET;
            state_in = ST_SU_CHK;
         end
         ST_SU_CHK: begin
            cmd.op   = OP_SU_CHK;
            state_in = sts.su_root ? ST_COUNT : ST_SU_CMP;
         end
         ST_SU_CMP: begin
            cmd.op   = OP_SU_CMP;
            state_in = sts.su_stop ? ST_COUNT : ST_SU_CHK;
         end
         ST_COUNT: begin
            cmd.op   = OP_COUNT;
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            // wait until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = OP_RESULT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_full_skips_heaps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid && sts.full) |=> state_ff == ST_COUNT)
      else $error("refused sample touched the heaps");
   a_result_loads_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_RESULT) |=> rsp_valid_ff)
      else $error("result transfer not presented");
endmodule

### rtl/rmth_dp.sv
// Running median datapath: two heap RAMs, top mirrors, sift unit, result register.
// Depends on rmth_pkg and rmth_ram.
module rmth_dp
   import rmth_pkg::*;
#(
   parameter int CAPACITY = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  cmd_type                    cmd,
   input  logic signed [SAMPLE_W-1:0] sample,
   output sts_type                    sts,
   output logic signed [SAMPLE_W-1:0] median_whole,
   output logic                       median_half,
   output logic [COUNT_OUT_W-1:0]     held_count,
   output logic                       full_res
);
   localparam int LD  = (CAPACITY + 1) / 2;
   localparam int UD  = CAPACITY / 2;
   localparam int IW  = (LD > 1) ? $clog2(LD) : 1;
   localparam int UAW = (UD > 1) ? $clog2(UD) : 1;
   localparam int SW  = IW + 1;
   localparam int EW  = IW + 2;
   localparam int CW  = $clog2(CAPACITY + 1);

   logic                       sel_ff, sel_in;   // 0: lower max-heap, 1: upper min-heap
   logic                       tsel_ff, tsel_in;
   logic signed [SAMPLE_W-1:0] val_ff, val_in;
   logic signed [SAMPLE_W-1:0] ins_ff, ins_in;
   logic signed [SAMPLE_W-1:0] lv_ff, lv_in;
   logic [IW-1:0]              idx_ff, idx_in;
   logic [IW-1:0]              pos_ff, pos_in;
   logic [SW-1:0]              size_ff, size_in;
   logic                       full_ff, full_in;
   logic [CW-1:0]              count_ff, count_in;
   logic signed [SAMPLE_W-1:0] ltop_ff, ltop_in;
   logic signed [SAMPLE_W-1:0] utop_ff, utop_in;
   logic signed [SAMPLE_W-1:0] whole_ff, whole_in;
   logic                       half_ff, half_in;
   logic [COUNT_OUT_W-1:0]     held_ff, held_in;
   logic                       fres_ff, fres_in;

   logic [SW-1:0]              lsz, usz;
   logic                       even, full_now, swap_now;
   logic [EW-1:0]              lch, rch, raddr;
   logic [IW-1:0]              parent;
   logic                       has_l, has_r, b1, b2, su_up;
   logic signed [SAMPLE_W-1:0] bv1, rdata, ldata, udata, wdata;
   logic                       wen;
   logic signed [SAMPLE_W:0]   sum;

   function automatic logic precedes(input logic signed [SAMPLE_W-1:0] a,
                                     input logic signed [SAMPLE_W-1:0] b,
                                     input logic is_min);
      precedes = is_min ? (a < b) : (a > b);
   endfunction

   assign lsz      = SW'(({1'b0, count_ff} + (CW + 1)'(1)) >> 1);
   assign usz      = SW'(count_ff >> 1);
   assign even     = !count_ff[0];
   assign full_now = (count_ff == CW'(CAPACITY));
   assign swap_now = even ? (usz != '0 && sample > utop_ff)
                          : (lsz != '0 && sample < ltop_ff);

   assign lch    = (EW'(idx_ff) << 1) + EW'(1);
   assign rch    = lch + EW'(1);
   assign parent = (idx_ff - IW'(1)) >> 1;
   assign has_l  = lch < EW'(size_ff);
   assign has_r  = rch < EW'(size_ff);
   assign rdata  = sel_ff ? udata : ldata;
   assign b1     = has_l && precedes(lv_ff, val_ff, sel_ff);
   assign bv1    = b1 ? lv_ff : val_ff;
   assign b2     = has_r && precedes(rdata, bv1, sel_ff);
   assign su_up  = precedes(val_ff, rdata, sel_ff);
   assign sum    = {ltop_ff[SAMPLE_W-1], ltop_ff} + {utop_ff[SAMPLE_W-1], utop_ff};

   always_comb begin
      case (cmd.op)
         OP_SD_L: raddr = lch;
         OP_SD_R: raddr = rch;
         default: raddr = EW'(parent);
      endcase
   end

   always_comb begin
      sel_in   = sel_ff;
      tsel_in  = tsel_ff;
      val_in   = val_ff;
      ins_in   = ins_ff;
      lv_in    = lv_ff;
      idx_in   = idx_ff;
      pos_in   = pos_ff;
      size_in  = size_ff;
      full_in  = full_ff;
      count_in = count_ff;
      whole_in = whole_ff;
      half_in  = half_ff;
      held_in  = held_ff;
      fres_in  = fres_ff;
      wen      = 1'b0;
      wdata    = val_ff;
      case (cmd.op)
         OP_START: begin
            full_in = full_now;
            val_in  = sample;
            tsel_in = !even;
            pos_in  = IW'(even ? lsz : usz);
            if (swap_now) begin
               sel_in  = even;
               idx_in  = '0;
               size_in = even ? usz : lsz;
               ins_in  = even ? utop_ff : ltop_ff;
            end else begin
               sel_in  = !even;
               idx_in  = IW'(even ? lsz : usz);
            end
         end
         OP_SD_L: begin
            if (!has_l) wen = 1'b1;
         end
         OP_SD_R: begin
            lv_in = rdata;
         end
         OP_SD_CMP: begin
            wen = 1'b1;
            if (b2) begin
               wdata  = rdata;
               idx_in = IW'(rch);
            end else if (b1) begin
               wdata  = lv_ff;
               idx_in = IW'(lch);
            end
         end
         OP_SU_SET: begin
            sel_in = tsel_ff;
            idx_in = pos_ff;
            val_in = ins_ff;
         end
         OP_SU_CHK: begin
            if (idx_ff == '0) wen = 1'b1;
         end
         OP_SU_CMP: begin
            wen = 1'b1;
            if (su_up) begin
               wdata  = rdata;
               idx_in = parent;
            end
         end
         OP_COUNT: begin
            if (!full_ff) count_in = count_ff + CW'(1);
         end
         OP_RESULT: begin
            held_in = COUNT_OUT_W'(count_ff);
            fres_in = full_ff;
            if (count_ff == '0) begin
               whole_in = '0;
               half_in  = 1'b0;
            end else if (count_ff[0]) begin
               whole_in = ltop_ff;
               half_in  = 1'b0;
            end else begin
               whole_in = sum[SAMPLE_W:1];
               half_in  = sum[0];
            end
         end
         default: begin
         end
      endcase
   end

   // top mirrors track every write to a root
   always_comb begin
      ltop_in = ltop_ff;
      utop_in = utop_ff;
      if (wen && idx_ff == '0) begin
         if (sel_ff) utop_in = wdata;
         else        ltop_in = wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      sel_ff   <= sel_in;
      tsel_ff  <= tsel_in;
      val_ff   <= val_in;
      ins_ff   <= ins_in;
      lv_ff    <= lv_in;
      idx_ff   <= idx_in;
      pos_ff   <= pos_in;
      size_ff  <= size_in;
      full_ff  <= full_in;
      ltop_ff  <= ltop_in;
      utop_ff  <= utop_in;
      whole_ff <= whole_in;
      half_ff  <= half_in;
      held_ff  <= held_in;
      fres_ff  <= fres_in;
   end

   rmth_ram #(.WIDTH(SAMPLE_W), .DEPTH(LD)) u_lower (
      .clock (clock),
      .we    (wen && !sel_ff),
      .waddr (idx_ff),
      .wdata (wdata),
      .raddr (raddr[IW-1:0]),
      .rdata (ldata)
   );

   rmth_ram #(.WIDTH(SAMPLE_W), .DEPTH(UD)) u_upper (
      .clock (clock),
      .we    (wen && sel_ff),
      .waddr (idx_ff[UAW-1:0]),
      .wdata (wdata),
      .raddr (raddr[UAW-1:0]),
      .rdata (udata)
   );

   assign sts.full    = full_now;
   assign sts.swap    = swap_now;
   assign sts.sd_leaf = !has_l;
   assign sts.sd_stop = !b1 && !b2;
   assign sts.su_root = (idx_ff == '0);
   assign sts.su_stop = !su_up;

   assign median_whole = whole_ff;
   assign median_half  = half_ff;
   assign held_count   = held_ff;
   assign full_res     = fres_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("sample count beyond capacity");
   a_full_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_COUNT && full_ff) |=> $stable(count_ff))
      else $error("refused sample changed the count");
   a_sd_descends: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_SD_CMP && (b1 || b2)) |=> idx_ff > $past(idx_ff))
      else $error("sift-down did not move toward the leaves");
endmodule
